@@ hw/rtl/srd_pkg.sv @@
// Shared types and constants of the scan reply distance decoder.
// Holds the line patterns, the result kind codes and the line phase type.
// No dependencies.
package srd_pkg;

    localparam int ECHO_LEN   = 12;
    localparam int STATUS_LEN = 3;

    localparam logic [8*ECHO_LEN-1:0]   ECHO_TEXT  = "GD0000108003";
    localparam logic [8*STATUS_LEN-1:0] OK_TEXT    = "00P";
    localparam logic [8*STATUS_LEN-1:0] RETRY_TEXT = "10Q";

    localparam logic [7:0]  LINE_FEED  = 8'h0A;
    localparam logic [5:0]  DIGIT_BASE = 6'h30;
    localparam logic [11:0] STEP_MAX   = 12'hFFF;
    localparam logic [4:0]  POS_MAX    = 5'd31;

    typedef enum logic [1:0] {
        PH_ECHO,
        PH_STATUS,
        PH_STAMP,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DIST  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_RETRY = 2'd2
    } t_kind;

    function automatic logic [7:0] echo_char(input logic [3:0] idx);
        return ECHO_TEXT[8*(ECHO_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] ok_char(input logic [1:0] idx);
        return OK_TEXT[8*(STATUS_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] retry_char(input logic [1:0] idx);
        return RETRY_TEXT[8*(STATUS_LEN-1-int'(idx)) +: 8];
    endfunction

endpackage

@@ hw/rtl/srd_if.sv @@
// Valid/ready channel interfaces of the scan reply distance decoder.
// srd_in_if carries received bytes, srd_out_if carries decoded results.
// No dependencies.
interface srd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface srd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] step_index;
    logic [17:0] distance;
    logic        leftover;

    modport source (output valid, output kind, output step_index, output distance,
                    output leftover, input ready);
    modport sink (input valid, input kind, input step_index, input distance,
                  input leftover, output ready);
endinterface

@@ hw/rtl/scan_reply_distance_decoder.sv @@
// Top level of the scan reply distance decoder.
// Depends on srd_pkg and the channel interfaces in srd_if.sv.
//
// Bytes of a rangefinder reply enter on i_rx, one per transaction. The block
// splits them into lines at LF, waits for the echo line and the "00P" status,
// skips the timestamp line and decodes the data characters but the last of each
// line, in threes into 18-bit distances. Results leave on o_res: a distance
// with its step, a scan done with the group count and a leftover flag, or a
// retry request. Each byte is captured in an input register and processed by
// the line parser, which loads the output register; the parser waits while a
// result stalls there. A result passes through both registers before it is
// offered. One byte can be accepted in every cycle while no result stalls on
// o_res. While a result waits on o_res, the input register still takes one
// more byte; i_rx.ready falls only when both registers are full and the result
// is not taken. Reset returns the parser to waiting for the echo line and
// empties both registers.
module scan_reply_distance_decoder
    import srd_pkg::*;
#(
    parameter int MAX_STEPS = 1081
) (
    input logic       i_clk,
    input logic       i_rst_n,
    srd_in_if.sink    i_rx,
    srd_out_if.source o_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [1:0]  r_match, n_match;
    logic [7:0]  r_held, n_held;
    logic        r_held_vld, n_held_vld;
    logic [11:0] r_grp, n_grp;
    logic [1:0]  r_gcnt, n_gcnt;
    logic [11:0] r_step, n_step;

    logic        res_valid;
    t_kind       res_kind;
    logic [11:0] res_step;
    logic [17:0] res_dist;
    logic        res_left;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [11:0] r_out_step;
    logic [17:0] r_out_dist;
    logic        r_out_left;

    logic        fire;
    logic [5:0]  digit;

    assign fire       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || fire;
    assign digit      = r_held[5:0] - DIGIT_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ECHO;
            r_pos      <= '0;
            r_match    <= 2'b11;
            r_held     <= '0;
            r_held_vld <= 1'b0;
            r_grp      <= '0;
            r_gcnt     <= '0;
            r_step     <= '0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_match    <= n_match;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_grp      <= n_grp;
            r_gcnt     <= n_gcnt;
            r_step     <= n_step;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_match    = r_match;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_grp      = r_grp;
        n_gcnt     = r_gcnt;
        n_step     = r_step;
        res_valid  = 1'b0;
        res_kind   = KIND_DIST;
        res_step   = '0;
        res_dist   = '0;
        res_left   = 1'b0;

        if (r_in_byte != LINE_FEED) begin
            unique case (r_phase)
                PH_ECHO: begin
                    if (r_pos >= 5'(ECHO_LEN) || r_in_byte != echo_char(r_pos[3:0])) begin
                        n_match[0] = 1'b0;
                    end
                end
                PH_STATUS: begin
                    if (r_pos >= 5'(STATUS_LEN) || r_in_byte != ok_char(r_pos[1:0])) begin
                        n_match[0] = 1'b0;
                    end
                    if (r_pos >= 5'(STATUS_LEN) || r_in_byte != retry_char(r_pos[1:0])) begin
                        n_match[1] = 1'b0;
                    end
                end
                PH_STAMP: begin
                end
                PH_DATA: begin
                    if (r_held_vld) begin
                        if (r_gcnt < 2'd2) begin
                            n_grp  = {r_grp[5:0], digit};
                            n_gcnt = r_gcnt + 2'd1;
                        end else begin
                            if (r_step < 12'(MAX_STEPS)) begin
                                res_valid = 1'b1;
                                res_kind  = KIND_DIST;
                                res_step  = r_step;
                                res_dist  = {r_grp, digit};
                            end
                            if (r_step != STEP_MAX) begin
                                n_step = r_step + 12'd1;
                            end
                            n_grp  = '0;
                            n_gcnt = '0;
                        end
                    end
                    n_held     = r_in_byte;
                    n_held_vld = 1'b1;
                end
            endcase
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 5'd1;
            end
        end else begin
            n_pos   = '0;
            n_match = 2'b11;
            unique case (r_phase)
                PH_ECHO: begin
                    if (r_match[0] && r_pos == 5'(ECHO_LEN)) begin
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (r_match[0] && r_pos == 5'(STATUS_LEN)) begin
                        n_phase    = PH_STAMP;
                        n_held     = '0;
                        n_held_vld = 1'b0;
                        n_grp      = '0;
                        n_gcnt     = '0;
                        n_step     = '0;
                    end else begin
                        n_phase = PH_ECHO;
                        if (r_match[1] && r_pos == 5'(STATUS_LEN)) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_RETRY;
                        end
                    end
                end
                PH_STAMP: begin
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (r_held_vld) begin
                        n_held_vld = 1'b0;
                        n_held     = '0;
                    end else begin
                        res_valid  = 1'b1;
                        res_kind   = KIND_DONE;
                        res_step   = r_step;
                        res_left   = (r_gcnt != 2'd0);
                        n_phase    = PH_ECHO;
                        n_held     = '0;
                        n_held_vld = 1'b0;
                        n_grp      = '0;
                        n_gcnt     = '0;
                        n_step     = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire && res_valid) begin
            r_out_kind <= res_kind;
            r_out_step <= res_step;
            r_out_dist <= res_dist;
            r_out_left <= res_left;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out_kind;
    assign o_res.step_index = r_out_step;
    assign o_res.distance   = r_out_dist;
    assign o_res.leftover   = r_out_left;

endmodule

@@ hw/rtl/srd_checker.sv @@
// Port-level checker of the scan reply distance decoder and its bind.
// Depends on srd_pkg for the result kind codes.
module srd_checker
    import srd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [11:0] i_out_step,
    input logic [17:0] i_out_dist,
    input logic        i_out_left
);

    // A stalled result must stay offered with unchanged fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_step) && $stable(i_out_dist) && $stable(i_out_left))
        else $error("result changed while stalled");

    // Input backpressure only appears when a result is waiting and not taken.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // Only a distance carries a distance; only a scan done carries the flag.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == KIND_DIST && !i_out_left)
            || (i_out_kind == KIND_DONE && i_out_dist == '0)
            || (i_out_kind == KIND_RETRY && i_out_dist == '0 && i_out_step == '0
                && !i_out_left))
        else $error("inconsistent result fields");

endmodule

bind scan_reply_distance_decoder srd_checker u_srd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.kind),
    .i_out_step  (o_res.step_index),
    .i_out_dist  (o_res.distance),
    .i_out_left  (o_res.leftover)
);

@@ tb/sv/scan_reply_distance_decoder_tb.sv @@
// Self-checking testbench for scan_reply_distance_decoder: byte streams in, decoded results out.
// A line parser here predicts all results but the directed scan end, which a table row gives.
// Depends on srd_pkg, the channel interfaces in srd_if.sv and the top level.
`timescale 1ns / 100ps

module scan_reply_distance_decoder_tb;
    import srd_pkg::*;

    localparam int SCAN_STEPS = 1081;
    localparam int CLK_PERIOD = 12;
    localparam int TOTAL_BYTES = 1150;

    typedef logic [8*ECHO_LEN-1:0] t_line;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] step_index;
        logic [17:0] distance;
        logic        leftover;
    } t_scan_result;

    typedef struct packed {
        logic [7:0]   rx_byte;
        logic         typed;
        t_scan_result result;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    srd_in_if  rx_if ();
    srd_out_if res_if ();

    scan_reply_distance_decoder #(
        .MAX_STEPS(SCAN_STEPS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_phase      line_phase = PH_ECHO;
    logic [4:0]  line_pos = '0;
    logic [1:0]  line_ok = 2'b11;
    logic [7:0]  held_char = '0;
    logic        held_valid = 1'b0;
    logic [11:0] group_value = '0;
    logic [1:0]  group_count = '0;
    logic [11:0] step_count = '0;

    t_scan_result pending_results[$];
    t_scan_result want;

    int mismatch_count = 0;
    int accepted_bytes = 0;
    int dist_seen = 0;
    int done_seen = 0;
    int retry_seen = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int gap_mix[4] = '{0, 54, 0, 20};
    int stall_mix[4] = '{0, 0, 54, 20};

    t_stim_row directed_rows[25] = '{
        '{"G", 1'b0, '0}, '{"D", 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0},
        '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"1", 1'b0, '0}, '{"0", 1'b0, '0},
        '{"8", 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"3", 1'b0, '0},
        '{LINE_FEED, 1'b0, '0},
        '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"P", 1'b0, '0}, '{LINE_FEED, 1'b0, '0},
        '{LINE_FEED, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{"o", 1'b0, '0}, '{"1", 1'b0, '0},
        '{"Z", 1'b0, '0}, '{LINE_FEED, 1'b0, '0},
        '{LINE_FEED, 1'b1, '{KIND_DONE, 12'd1, 18'd0, 1'b1}}
    };

    function automatic void clear_scan_state();
        held_char = '0;
        held_valid = 1'b0;
        group_value = '0;
        group_count = '0;
        step_count = '0;
    endfunction

    function automatic void expect_result(input t_scan_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic bit parse_reply_byte(input logic [7:0] c, output t_scan_result r);
        logic [5:0] digit;
        bit         got;
        got = 1'b0;
        r = '0;
        if (c != LINE_FEED) begin
            if (line_phase == PH_ECHO) begin
                if (line_pos >= ECHO_LEN
                        || c != ECHO_TEXT[8*(ECHO_LEN-1-int'(line_pos)) +: 8]) begin
                    line_ok[0] = 1'b0;
                end
            end else if (line_phase == PH_STATUS) begin
                if (line_pos >= STATUS_LEN
                        || c != OK_TEXT[8*(STATUS_LEN-1-int'(line_pos)) +: 8]) begin
                    line_ok[0] = 1'b0;
                end
                if (line_pos >= STATUS_LEN
                        || c != RETRY_TEXT[8*(STATUS_LEN-1-int'(line_pos)) +: 8]) begin
                    line_ok[1] = 1'b0;
                end
            end
            if (line_pos != POS_MAX) line_pos = line_pos + 5'd1;
            if (line_phase == PH_DATA) begin
                if (held_valid) begin
                    digit = held_char[5:0] - DIGIT_BASE;
                    if (group_count < 2) begin
                        group_value = {group_value[5:0], digit};
                        group_count = group_count + 2'd1;
                    end else begin
                        if (step_count < SCAN_STEPS) begin
                            r.kind = KIND_DIST;
                            r.step_index = step_count;
                            r.distance = {group_value, digit};
                            got = 1'b1;
                        end
                        if (step_count != STEP_MAX) step_count = step_count + 12'd1;
                        group_value = '0;
                        group_count = '0;
                    end
                end
                held_char = c;
                held_valid = 1'b1;
            end
        end else begin
            case (line_phase)
                PH_ECHO: begin
                    line_phase = (line_ok[0] && line_pos == ECHO_LEN) ? PH_STATUS : PH_ECHO;
                end
                PH_STATUS: begin
                    if (line_ok[0] && line_pos == STATUS_LEN) begin
                        clear_scan_state();
                        line_phase = PH_STAMP;
                    end else begin
                        line_phase = PH_ECHO;
                        if (line_ok[1] && line_pos == STATUS_LEN) begin
                            r.kind = KIND_RETRY;
                            got = 1'b1;
                        end
                    end
                end
                PH_STAMP: begin
                    line_phase = PH_DATA;
                end
                default: begin
                    if (held_valid) begin
                        held_valid = 1'b0;
                        held_char = '0;
                    end else begin
                        r.kind = KIND_DONE;
                        r.step_index = step_count;
                        r.leftover = (group_count != 0);
                        got = 1'b1;
                        clear_scan_state();
                        line_phase = PH_ECHO;
                    end
                end
            endcase
            line_pos = '0;
            line_ok = 2'b11;
        end
        return got;
    endfunction

    function automatic logic [7:0] random_non_lf();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == LINE_FEED) b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic void note_mismatch(input string field, input int unsigned exp_v,
                                          input int unsigned act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        mismatch_count++;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed, input t_scan_result fixed);
        t_scan_result r;
        bit           got;
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        got = parse_reply_byte(b, r);
        if (typed) expect_result(fixed);
        else if (got) expect_result(r);
        accepted_bytes++;
    endtask

    task automatic put(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic send_line(input t_line text, input int n);
        for (int i = 0; i < n; i++) put(text[8*(n-1-i) +: 8]);
        put(LINE_FEED);
    endtask

    task automatic send_scan(input int lines, input int min_len, input int max_len);
        int len;
        send_line(ECHO_TEXT, ECHO_LEN);
        send_line(t_line'(OK_TEXT), STATUS_LEN);
        repeat ($urandom_range(12)) put(random_non_lf());
        put(LINE_FEED);
        for (int l = 0; l < lines; l++) begin
            len = $urandom_range(max_len, min_len);
            for (int i = 0; i < len; i++) begin
                if (i < len - 1 && $urandom_range(99) < 85) begin
                    put(8'($urandom_range(8'h6F, 8'h30)));
                end else begin
                    put(random_non_lf());
                end
            end
            put(LINE_FEED);
        end
        put(LINE_FEED);
    endtask

    task automatic send_broken();
        t_line text;
        case ($urandom_range(4))
            0: begin
                text = ECHO_TEXT;
                text[8*$urandom_range(ECHO_LEN-1) +: 8] = random_non_lf();
                if ($urandom_range(1)) send_line(text, ECHO_LEN);
                else send_line(ECHO_TEXT >> 8, ECHO_LEN - 1);
                send_line(t_line'(OK_TEXT), STATUS_LEN);
            end
            1: begin
                send_line(ECHO_TEXT, ECHO_LEN);
                case ($urandom_range(3))
                    0: send_line(ECHO_TEXT, ECHO_LEN);
                    1: send_line(t_line'({OK_TEXT, random_non_lf()}), STATUS_LEN + 1);
                    2: send_line(t_line'(RETRY_TEXT >> 8), STATUS_LEN - 1);
                    default: begin
                        repeat ($urandom_range(5)) put(random_non_lf());
                        put(LINE_FEED);
                    end
                endcase
            end
            2: begin
                repeat ($urandom_range(40, 5)) begin
                    if ($urandom_range(9) == 0) put(LINE_FEED);
                    else put(8'($urandom_range(255)));
                end
                put(LINE_FEED);
            end
            3: begin
                for (int i = 0; i < ECHO_LEN; i++) put(ECHO_TEXT[8*(ECHO_LEN-1-i) +: 8]);
                repeat ($urandom_range(30, 1)) put(random_non_lf());
                put(LINE_FEED);
                send_line(t_line'(OK_TEXT), STATUS_LEN);
            end
            default: begin
                send_line(ECHO_TEXT, ECHO_LEN);
                put(LINE_FEED);
            end
        endcase
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            case (res_if.kind)
                KIND_DIST: dist_seen++;
                KIND_DONE: done_seen++;
                default: retry_seen++;
            endcase
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, kind %0d step %0d distance %0d",
                         $time, res_if.kind, res_if.step_index, res_if.distance);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.kind !== want.kind) note_mismatch("kind", want.kind, res_if.kind);
                if (res_if.step_index !== want.step_index) begin
                    note_mismatch("step_index", want.step_index, res_if.step_index);
                end
                if (res_if.distance !== want.distance) begin
                    note_mismatch("distance", want.distance, res_if.distance);
                end
                if (res_if.leftover !== want.leftover) begin
                    note_mismatch("leftover", want.leftover, res_if.leftover);
                end
            end
        end
    end

    initial begin
        int pick;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].result);
        end
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = gap_mix[ph];
            recv_stall_pct = stall_mix[ph];
            if (ph == 0) begin
                hold_request = 150;
                send_scan(3, 30, 40);
                wait_drained();
            end
            while (accepted_bytes < (ph + 1) * TOTAL_BYTES / 4) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    send_scan($urandom_range(4, 1), 1, $urandom_range(40, 1));
                end else if (pick < 75) begin
                    send_line(ECHO_TEXT, ECHO_LEN);
                    send_line(t_line'(RETRY_TEXT), STATUS_LEN);
                end else begin
                    send_broken();
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("Sent %0d bytes: a directed scan, random scans, retries and broken lines.",
                 accepted_bytes);
        $display("Checked %0d distances, %0d scan ends and %0d retry requests.",
                 dist_seen, done_seen, retry_seen);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** scan_reply_distance_decoder: PASSED **");
        end else begin
            $display("** scan_reply_distance_decoder: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results still expected.", pending_results.size());
        $display("** scan_reply_distance_decoder: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/srd_pkg.sv
hw/rtl/srd_if.sv
hw/rtl/scan_reply_distance_decoder.sv
hw/rtl/srd_checker.sv
tb/sv/scan_reply_distance_decoder_tb.sv
